### hdl/ggav_pkg.sv
// Shared types and constants for the GGA sentence validator.
// Character codes, grammar phases, item structs and result queue sizing.
// No dependencies.
package ggav_pkg;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_M   = 8'h6D;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_S   = 8'h73;
  localparam logic [7:0] CH_LC_W   = 8'h77;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // Line length tracking
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_SAT   = 7'd127;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd84;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_MAX_LINE_LEN = 1'b0;

  // Result queue: room for the two results of one end-of-stream item
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;
  localparam logic [RES_CNT_W-1:0] RES_ROOM_LIMIT = 3'(RES_DEPTH - 2);

  // Grammar position within a line
  typedef enum logic [4:0] {
    PH_DOLLAR    = 5'd0,
    PH_TALKER    = 5'd1,
    PH_TIME      = 5'd2,
    PH_LAT       = 5'd3,
    PH_NS        = 5'd4,
    PH_NS_SEP    = 5'd5,
    PH_LON       = 5'd6,
    PH_EW        = 5'd7,
    PH_EW_SEP    = 5'd8,
    PH_FIX       = 5'd9,
    PH_SAT       = 5'd10,
    PH_HDOP      = 5'd11,
    PH_ALT       = 5'd12,
    PH_UNIT1     = 5'd13,
    PH_UNIT1_SEP = 5'd14,
    PH_SEP       = 5'd15,
    PH_UNIT2     = 5'd16,
    PH_TAIL      = 5'd17
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_VALID   = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_END     = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] checksum;
    logic       last_result;
  } out_item_t;

  // Results produced by one processed item, oldest first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
  } res_bundle_t;

endpackage

### hdl/ggav_cfg.sv
// APB-style register port for the GGA sentence validator.
// Holds max_line_length. Depends on ggav_pkg.
module ggav_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ggav_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [ggav_pkg::LEN_W-1:0]      max_len_o
);
  import ggav_pkg::*;

  logic [LEN_W-1:0] max_len_q;
  logic             wr_en;
  logic             sel_len;

  assign pready  = 1'b1;
  assign sel_len = (paddr[APB_ADDR_W-1] == REG_MAX_LINE_LEN);
  assign wr_en   = psel && penable && pwrite && pready && sel_len;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LEN_RESET;
    end else if (wr_en) begin
      max_len_q <= pwdata[LEN_W-1:0];
    end
  end

  // Read back; addresses beyond the register read as zero
  always_comb begin
    prdata = '0;
    if (sel_len) begin
      prdata = {{(32-LEN_W){1'b0}}, max_len_q};
    end
  end

  assign max_len_o = max_len_q;

endmodule

### hdl/ggav_parse.sv
// Per-byte grammar tracker and checksum for GGA lines.
// Holds all line state and forms the results of one item. Depends on ggav_pkg.
module ggav_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  ggav_pkg::in_item_t         item_i,
  input  logic [ggav_pkg::LEN_W-1:0] max_len_i,
  output ggav_pkg::res_bundle_t      res_o
);
  import ggav_pkg::*;

  phase_e           phase_q, phase_d;
  logic             dot_q, dot_d;
  logic [7:0]       xor_q, xor_d;
  logic             xact_q, xact_d;
  logic             star_q, star_d;
  logic             err_q, err_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;

  logic [7:0]       b;
  logic [7:0]       low;
  logic             is_digit;
  verdict_e         line_verdict;

  assign b        = item_i.byte_in;
  assign low      = b | CASE_BIT;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign line_verdict = (!err_q && phase_q == PH_TAIL && star_q) ? VERDICT_VALID
                                                                 : VERDICT_INVALID;

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DOLLAR;
      dot_q   <= 1'b0;
      xor_q   <= '0;
      xact_q  <= 1'b0;
      star_q  <= 1'b0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      dot_q   <= dot_d;
      xor_q   <= xor_d;
      xact_q  <= xact_d;
      star_q  <= star_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Next line state and results
  always_comb begin
    phase_d = phase_q;
    dot_d   = dot_q;
    xor_d   = xor_q;
    xact_d  = xact_q;
    star_d  = star_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    res_o   = '0;

    if (fire_i) begin
      if (item_i.end_of_stream || b == CH_NL) begin
        // line ends: report and clear
        if (item_i.end_of_stream) begin
          if (pend_q) begin
            res_o.count = 2'd2;
            res_o.r0    = '{verdict: line_verdict, checksum: xor_q, last_result: 1'b0};
            res_o.r1    = '{verdict: VERDICT_END, checksum: 8'h00, last_result: 1'b1};
          end else begin
            res_o.count = 2'd1;
            res_o.r0    = '{verdict: VERDICT_END, checksum: 8'h00, last_result: 1'b1};
          end
        end else begin
          res_o.count = 2'd1;
          res_o.r0    = '{verdict: line_verdict, checksum: xor_q, last_result: 1'b1};
        end
        phase_d = PH_DOLLAR;
        dot_d   = 1'b0;
        xor_d   = '0;
        xact_d  = 1'b0;
        star_d  = 1'b0;
        err_d   = 1'b0;
        cnt_d   = '0;
        pend_d  = 1'b0;
      end else begin
        pend_d = 1'b1;
        if (cnt_q >= max_len_i) begin
          err_d = 1'b1;
        end
        if (cnt_q != LEN_SAT) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (b == CH_STAR) begin
          star_d = 1'b1;
        end
        // checksum runs from after the dollar up to the first star
        if (xact_q) begin
          if (b == CH_STAR) begin
            xact_d = 1'b0;
          end else begin
            xor_d = xor_q ^ b;
          end
        end

        // grammar step, only while the line is still good
        if (!err_d) begin
          unique case (phase_q)
            PH_DOLLAR: begin
              if (b == CH_DOLLAR) begin
                phase_d = PH_TALKER;
                xact_d  = 1'b1;
              end else begin
                err_d = 1'b1;
              end
            end
            PH_TALKER: begin
              if (b == CH_COMMA) begin
                phase_d = PH_TIME;
              end
            end
            PH_TIME, PH_LAT, PH_LON, PH_FIX, PH_SAT, PH_HDOP, PH_ALT, PH_SEP: begin
              if (is_digit) begin
                phase_d = phase_q;
              end else if (b == CH_DOT) begin
                if (dot_q) begin
                  err_d = 1'b1;
                end
                dot_d = 1'b1;
              end else if (b == CH_COMMA) begin
                dot_d = 1'b0;
                case (phase_q)
                  PH_TIME: phase_d = PH_LAT;
                  PH_LAT:  phase_d = PH_NS;
                  PH_LON:  phase_d = PH_EW;
                  PH_FIX:  phase_d = PH_SAT;
                  PH_SAT:  phase_d = PH_HDOP;
                  PH_HDOP: phase_d = PH_ALT;
                  PH_ALT:  phase_d = PH_UNIT1;
                  default: phase_d = PH_UNIT2;
                endcase
              end else begin
                err_d = 1'b1;
              end
            end
            PH_NS: begin
              if (low == CH_LC_N || low == CH_LC_S) begin
                phase_d = PH_NS_SEP;
              end else begin
                err_d = 1'b1;
              end
            end
            PH_EW: begin
              if (low == CH_LC_E || low == CH_LC_W) begin
                phase_d = PH_EW_SEP;
              end else begin
                err_d = 1'b1;
              end
            end
            PH_UNIT1: begin
              if (low == CH_LC_M) begin
                phase_d = PH_UNIT1_SEP;
              end else begin
                err_d = 1'b1;
              end
            end
            PH_NS_SEP, PH_EW_SEP, PH_UNIT1_SEP: begin
              if (b == CH_COMMA) begin
                case (phase_q)
                  PH_NS_SEP: phase_d = PH_LON;
                  PH_EW_SEP: phase_d = PH_FIX;
                  default:   phase_d = PH_SEP;
                endcase
              end else begin
                err_d = 1'b1;
              end
            end
            PH_UNIT2: begin
              if (low == CH_LC_M) begin
                phase_d = PH_TAIL;
              end else begin
                err_d = 1'b1;
              end
            end
            PH_TAIL: begin
              phase_d = PH_TAIL;
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // a newline or end of stream always leaves a clean line behind
  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.end_of_stream || b == CH_NL)
    |=> phase_q == PH_DOLLAR && cnt_q == '0 && !pend_q && !xact_q)
    else $error("line state not cleared at end of line");

  // ordinary bytes never produce results
  a_no_result_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!fire_i || (!item_i.end_of_stream && b != CH_NL)) |-> res_o.count == 2'd0)
    else $error("result produced by an ordinary byte");

  // the final result of an item is always marked last
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.count == 2'd1 |-> res_o.r0.last_result) and
    (res_o.count == 2'd2 |-> (!res_o.r0.last_result && res_o.r1.last_result)))
    else $error("last_result marking broken");

endmodule

### hdl/ggav_rfifo.sv
// Result queue for the GGA sentence validator: takes up to two results a cycle,
// hands out one while the receiver is ready. Depends on ggav_pkg.
module ggav_rfifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ggav_pkg::res_bundle_t push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ggav_pkg::out_item_t   out_data_o
);
  import ggav_pkg::*;

  out_item_t            mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr_q, wptr_d;
  logic [RES_PTR_W-1:0] rptr_q, rptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [RES_PTR_W-1:0] wptr_nx;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign room_o      = (cnt_q <= RES_ROOM_LIMIT);
  assign wptr_nx     = wptr_q + 1'b1;

  // Pointer and fill arithmetic
  always_comb begin
    wptr_d = wptr_q + RES_PTR_W'(push_i.count);
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + RES_CNT_W'(push_i.count) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_nx] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> ({1'b0, cnt_q} + {2'b00, push_i.count}) <= (RES_CNT_W+1)'(RES_DEPTH))
    else $error("result queue overflow");

  a_fill_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 3'(RES_DEPTH) |-> RES_PTR_W'(wptr_q - rptr_q) == cnt_q[RES_PTR_W-1:0])
    else $error("fill count out of step with pointers");

endmodule

### hdl/nmea_gga_sentence_validator_unit.sv
// GGA sentence validator, top level: input register, parser, result queue, registers.
// Depends on ggav_pkg, ggav_cfg, ggav_parse, ggav_rfifo.
//
// Takes one NMEA character per cycle, sustained, and reports one verdict with the
// line checksum per newline. An end-of-stream item gives one result, or two when
// a line is still open; an open line always holds a byte that gave no result, so
// the four-entry result queue keeps up with one item per cycle and the input
// stalls only while the receiver holds off. An accepted item is held in the input
// register, then passes through the per-byte grammar step into the result queue,
// where its result can be taken. max_line_length is written over the APB port at
// byte address 0 and applies from the next byte; there is no clearing pass after
// reset.
module nmea_gga_sentence_validator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ggav_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ggav_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ggav_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ggav_pkg::*;

  logic             in_vld_q;
  in_item_t         in_q;
  logic             room;
  logic             fire;
  logic [LEN_W-1:0] max_len;
  res_bundle_t      res;

  // Input register: refills whenever it is empty or its item moves on
  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  ggav_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  ggav_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_q),
    .max_len_i (max_len),
    .res_o     (res)
  );

  ggav_rfifo u_rfifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a held item is never dropped while the queue is full
  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !room |=> in_vld_q && $stable(in_q))
    else $error("input register lost an item");

  // with an empty input register the block always takes an item
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("input stalled with empty register");

  // nothing is processed without a held item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> res.count == 2'd0)
    else $error("result formed without an item");

endmodule
